// ----- rtl/core/gpq_pkg.sv -----
// Shared types and constants for the graph path query engine.
// No dependencies; compiled first.
`default_nettype none

package gpq_pkg;

   localparam int CMD_W   = 3;
   localparam int VTX_W   = 3;
   localparam int COUNT_W = 11;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_EDGE    = 3'd0,
      CMD_DEL_EDGE    = 3'd1,
      CMD_DEL_VERTEX  = 3'd2,
      CMD_HAS_PATH    = 3'd3,
      CMD_COUNT_PATHS = 3'd4
   } command_type;

   // Update request into the adjacency matrix
   typedef struct packed {
      logic        en;
      command_type op;
   } adj_upd_type;

   // Walker control and status
   typedef struct packed {
      logic start;
      logic stop_first;
   } walk_ctl_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] count;
   } walk_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/gpq_req_if.sv -----
// Command channel: valid/ready with the command item payload.
// Depends on gpq_pkg.
`default_nettype none

interface gpq_req_if;
   import gpq_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VTX_W-1:0]   vertex_a;
   logic [VTX_W-1:0]   vertex_b;

   modport source (output valid, command, vertex_a, vertex_b, input ready);
   modport sink   (input valid, command, vertex_a, vertex_b, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gpq_rsp_if.sv -----
// Result channel: valid/ready with found flag and path count.
// Depends on gpq_pkg.
`default_nettype none

interface gpq_rsp_if;
   import gpq_pkg::*;

   logic               valid;
   logic               ready;
   logic               found;
   logic [COUNT_W-1:0] path_count;

   modport source (output valid, found, path_count, input ready);
   modport sink   (input valid, found, path_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gpq_adj.sv -----
// Adjacency bit matrix of the undirected graph, with update and row read.
// Depends on gpq_pkg.
`default_nettype none

module gpq_adj #(
   parameter int NUM_VERTICES = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gpq_pkg::adj_upd_type            upd,
   input  wire logic [$clog2(NUM_VERTICES)-1:0] upd_a,
   input  wire logic [$clog2(NUM_VERTICES)-1:0] upd_b,
   input  wire logic [$clog2(NUM_VERTICES)-1:0] rd_sel,
   output logic      [NUM_VERTICES-1:0]         rd_row
);
   import gpq_pkg::*;

   logic [NUM_VERTICES-1:0] adj_ff [NUM_VERTICES];
   logic [NUM_VERTICES-1:0] adj_in [NUM_VERTICES];

   always_comb begin
      adj_in = adj_ff;
      if (upd.en) begin
         unique case (upd.op)
            CMD_ADD_EDGE: begin
               // self-loops are dropped
               if (upd_a != upd_b) begin
                  adj_in[upd_a][upd_b] = 1'b1;
                  adj_in[upd_b][upd_a] = 1'b1;
               end
            end
            CMD_DEL_EDGE: begin
               adj_in[upd_a][upd_b] = 1'b0;
               adj_in[upd_b][upd_a] = 1'b0;
            end
            CMD_DEL_VERTEX: begin
               for (int r = 0; r < NUM_VERTICES; r++) begin
                  adj_in[r][upd_a] = 1'b0;
               end
               adj_in[upd_a] = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_VERTICES; r++) begin
            adj_ff[r] <= '0;
         end
      end else begin
         adj_ff <= adj_in;
      end
   end

   assign rd_row = adj_ff[rd_sel];

endmodule

`default_nettype wire

// ----- rtl/core/gpq_walker.sv -----
// Depth-first walker: one stack step per cycle over the adjacency rows.
// Depends on gpq_pkg; reads the matrix through a row port.
`default_nettype none

module gpq_walker #(
   parameter int NUM_VERTICES = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gpq_pkg::walk_ctl_type           ctl,
   input  wire logic [$clog2(NUM_VERTICES)-1:0] src,
   input  wire logic [$clog2(NUM_VERTICES)-1:0] dst,
   output logic      [$clog2(NUM_VERTICES)-1:0] row_sel,
   input  wire logic [NUM_VERTICES-1:0]         row,
   output gpq_pkg::walk_stat_type               stat
);
   import gpq_pkg::*;

   localparam int VtxW = $clog2(NUM_VERTICES);
   localparam int CurW = $clog2(NUM_VERTICES + 1);
   localparam int DepW = $clog2(NUM_VERTICES + 1);

   // stacks: no reset, every entry written before read
   logic [VtxW-1:0] vstack_ff [NUM_VERTICES];
   logic [CurW-1:0] nstack_ff [NUM_VERTICES];

   logic                    active_ff, active_in;
   logic                    stop_ff, stop_in;
   logic [VtxW-1:0]         dst_ff, dst_in;
   logic [DepW-1:0]         depth_ff, depth_in;
   logic [NUM_VERTICES-1:0] visited_ff, visited_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    done_ff, done_in;

   logic [DepW-1:0] top_full;
   logic [VtxW-1:0] top_idx;
   logic [VtxW-1:0] push_idx;
   logic [VtxW-1:0] cur_v;
   logic [CurW-1:0] cur_n;
   logic [VtxW-1:0] n_idx;
   logic            step;
   logic            exhausted;
   logic            hit;
   logic            at_dst;
   logic            push;

   assign top_full  = depth_ff - DepW'(1);
   assign top_idx   = top_full[VtxW-1:0];
   assign push_idx  = depth_ff[VtxW-1:0];
   assign cur_v     = vstack_ff[top_idx];
   assign cur_n     = nstack_ff[top_idx];
   assign n_idx     = cur_n[VtxW-1:0];
   assign row_sel   = cur_v;

   assign step      = active_ff && (depth_ff != '0);
   assign exhausted = cur_n >= CurW'(NUM_VERTICES);
   assign hit       = step && !exhausted && row[n_idx] && !visited_ff[n_idx];
   assign at_dst    = n_idx == dst_ff;
   assign push      = hit && !at_dst && (depth_ff < DepW'(NUM_VERTICES));

   always_comb begin
      active_in  = active_ff;
      stop_in    = stop_ff;
      dst_in     = dst_ff;
      depth_in   = depth_ff;
      visited_in = visited_ff;
      count_in   = count_ff;
      done_in    = 1'b0;
      if (ctl.start) begin
         active_in       = 1'b1;
         stop_in         = ctl.stop_first;
         dst_in          = dst;
         depth_in        = DepW'(1);
         visited_in      = '0;
         visited_in[src] = 1'b1;
         count_in        = '0;
      end else if (active_ff) begin
         if (depth_ff == '0) begin
            // stack empty: walk over
            active_in = 1'b0;
            done_in   = 1'b1;
         end else if (exhausted) begin
            visited_in[cur_v] = 1'b0;
            depth_in          = depth_ff - DepW'(1);
         end else if (hit && at_dst) begin
            if (count_ff < COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            if (stop_ff) begin
               active_in = 1'b0;
               done_in   = 1'b1;
            end
         end else if (push) begin
            visited_in[n_idx] = 1'b1;
            depth_in          = depth_ff + DepW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         done_ff    <= 1'b0;
         depth_ff   <= '0;
         visited_ff <= '0;
         count_ff   <= '0;
      end else begin
         active_ff  <= active_in;
         done_ff    <= done_in;
         depth_ff   <= depth_in;
         visited_ff <= visited_in;
         count_ff   <= count_in;
      end
      stop_ff <= stop_in;
      dst_ff  <= dst_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         vstack_ff[0] <= src;
         nstack_ff[0] <= '0;
      end else begin
         if (step && !exhausted) begin
            nstack_ff[top_idx] <= cur_n + CurW'(1);
         end
         if (push) begin
            vstack_ff[push_idx] <= n_idx;
            nstack_ff[push_idx] <= '0;
         end
      end
   end

   assign stat.done  = done_ff;
   assign stat.count = count_ff;

endmodule

`default_nettype wire

// ----- rtl/core/graph_path_query_engine.sv -----
// Graph path query engine top level: command decode, sequencer, result register.
// Depends on gpq_pkg, gpq_req_if, gpq_rsp_if, gpq_adj and gpq_walker.
//
// Usage
//  - req_ch carries one command item: add edge, remove edge, remove vertex,
//    has path or count paths. rsp_ch returns exactly one item per command:
//    found and a saturating 11-bit path_count.
//  - req_ch.ready is high only while the sequencer is idle; one command is
//    worked at a time.
//  - Updates: the matrix is written in the exec state; the result then leaves
//    the finish state for the output register. Queries: one depth-first step
//    per cycle through the walker, which reads one adjacency row a cycle;
//    a step is one neighbour trial or one pop.
//  - The result register parts the two sides: a new command is accepted
//    while an earlier result still waits on rsp_ch.ready. A finished result
//    waits in the sequencer until that register frees up.
//  - Reset (synchronous, active high) empties the graph, drops any walk in
//    flight and any result not yet taken.
`default_nettype none

module graph_path_query_engine #(
   parameter int NUM_VERTICES = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   gpq_req_if.sink   req_ch,
   gpq_rsp_if.source rsp_ch
);
   import gpq_pkg::*;

   localparam int VtxW = $clog2(NUM_VERTICES);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // latched command item
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [VTX_W-1:0] va_ff, va_in;
   logic [VTX_W-1:0] vb_ff, vb_in;

   // result waiting for the output register
   logic               res_found_ff, res_found_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic            req_take;
   logic            out_free;
   logic            a_ok;
   logic            b_ok;
   logic            is_query;
   logic            is_count;
   logic [VtxW-1:0] a_idx;
   logic [VtxW-1:0] b_idx;

   adj_upd_type             adj_upd;
   walk_ctl_type            walk_ctl;
   walk_stat_type           walk_stat;
   logic [VtxW-1:0]         row_sel;
   logic [NUM_VERTICES-1:0] row;

   assign req_ch.ready = state_ff == ST_IDLE;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // vertices beyond the graph make the command a no-op
   assign a_ok     = int'(va_ff) < NUM_VERTICES;
   assign b_ok     = int'(vb_ff) < NUM_VERTICES;
   assign a_idx    = VtxW'(va_ff);
   assign b_idx    = VtxW'(vb_ff);
   assign is_count = cmd_ff == CMD_COUNT_PATHS;
   assign is_query = (cmd_ff == CMD_HAS_PATH) || is_count;

   always_comb begin
      adj_upd.op = command_type'(cmd_ff);
      adj_upd.en = 1'b0;
      if (state_ff == ST_EXEC) begin
         if (cmd_ff == CMD_DEL_VERTEX) begin
            adj_upd.en = a_ok;
         end else if ((cmd_ff == CMD_ADD_EDGE) || (cmd_ff == CMD_DEL_EDGE)) begin
            adj_upd.en = a_ok && b_ok;
         end
      end
   end

   assign walk_ctl.start      = (state_ff == ST_EXEC) && is_query && a_ok && b_ok &&
                                (a_idx != b_idx);
   assign walk_ctl.stop_first = !is_count;

   gpq_adj #(
      .NUM_VERTICES(NUM_VERTICES)
   ) u_adj (
      .clock (clock),
      .reset (reset),
      .upd   (adj_upd),
      .upd_a (a_idx),
      .upd_b (b_idx),
      .rd_sel(row_sel),
      .rd_row(row)
   );

   gpq_walker #(
      .NUM_VERTICES(NUM_VERTICES)
   ) u_walker (
      .clock  (clock),
      .reset  (reset),
      .ctl    (walk_ctl),
      .src    (a_idx),
      .dst    (b_idx),
      .row_sel(row_sel),
      .row    (row),
      .stat   (walk_stat)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      res_found_in = res_found_ff;
      res_count_in = res_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in   = req_ch.command;
               va_in    = req_ch.vertex_a;
               vb_in    = req_ch.vertex_b;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_found_in = 1'b0;
            res_count_in = '0;
            state_in     = ST_FINISH;
            if (walk_ctl.start) begin
               state_in = ST_WALK;
            end else if (is_query && a_ok && b_ok) begin
               // same endpoints: the trivial path
               res_found_in = 1'b1;
               res_count_in = is_count ? COUNT_W'(1) : '0;
            end
         end
         ST_WALK: begin
            if (walk_stat.done) begin
               res_found_in = walk_stat.count != '0;
               res_count_in = is_count ? walk_stat.count : '0;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_count_in = res_count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      va_ff        <= va_in;
      vb_ff        <= vb_in;
      res_found_ff <= res_found_in;
      res_count_ff <= res_count_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.path_count = rsp_count_ff;

   // walker only reports while the sequencer waits on it
   a_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_stat.done |-> state_ff == ST_WALK)
      else $error("walker done outside walk state");

   // a nonzero count always comes with found
   a_count_implies_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.found) |-> rsp_ch.path_count == '0)
      else $error("path count without found");

   // an accepted command is decoded in the next cycle
   a_take_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_EXEC)
      else $error("accepted command not decoded");

endmodule

`default_nettype wire
